FILE: sv/tkpst_pkg.sv
package tkpst_pkg;

    localparam int METRIC_W      = 16;
    localparam int N_METRICS     = 7;
    localparam int SCORE_W       = 32;
    localparam int TAG_W         = 35;
    localparam int RANK_W        = 6;
    localparam int TOP_COUNT_DEF = 64;
    localparam int STEP_W        = 3;
    localparam int PROD_W        = SCORE_W + METRIC_W;

    localparam int IN_DATA_W  = ((N_METRICS * METRIC_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RANK_W + SCORE_W + TAG_W + 7) / 8) * 8;
    localparam int TAG_LSB    = N_METRICS * METRIC_W;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef logic [N_METRICS-1:0][METRIC_W-1:0] metric_vec_t;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctrl_t;

endpackage

FILE: sv/tkpst_mul.sv
module tkpst_mul
    import tkpst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  metric_vec_t        metrics,
    output logic               done,
    output logic [SCORE_W-1:0] score
);

    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(1);
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(N_METRICS - 1);

    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    metric_vec_t        metrics_reg;
    logic [SCORE_W-1:0] acc_reg;
    logic [PROD_W-1:0]  prod;

    assign prod = {{METRIC_W{1'b0}}, acc_reg} * {{SCORE_W{1'b0}}, metrics_reg[step_reg]};

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = FIRST_STEP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= FIRST_STEP;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // first product is exact, later ones drop 16 fraction bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            metrics_reg <= metrics;
            acc_reg     <= {{(SCORE_W - METRIC_W){1'b0}}, metrics[0]};
        end
        else if (busy_reg)
        begin
            if (step_reg == FIRST_STEP)
            begin
                acc_reg <= prod[SCORE_W-1:0];
            end
            else
            begin
                acc_reg <= prod[PROD_W-1:METRIC_W];
            end
        end
    end

    assign done  = done_reg;
    assign score = acc_reg;

endmodule

FILE: sv/tkpst_cell.sv
module tkpst_cell
    import tkpst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [SCORE_W-1:0] new_score,
    input  logic [TAG_W-1:0]   new_tag,
    input  logic               up_gt,
    input  logic [SCORE_W-1:0] up_score,
    input  logic [TAG_W-1:0]   up_tag,
    input  logic [SCORE_W-1:0] dn_score,
    input  logic [TAG_W-1:0]   dn_tag,
    output logic               gt,
    output logic [SCORE_W-1:0] score,
    output logic [TAG_W-1:0]   tag
);

    logic [SCORE_W-1:0] score_reg, score_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;

    assign gt = new_score > score_reg;

    always_comb
    begin
        priority if (ctrl.ins && up_gt)
        begin
            score_next = up_score;
            tag_next   = up_tag;
        end
        else if (ctrl.ins && gt)
        begin
            score_next = new_score;
            tag_next   = new_tag;
        end
        else if (ctrl.rot)
        begin
            score_next = dn_score;
            tag_next   = dn_tag;
        end
        else
        begin
            score_next = score_reg;
            tag_next   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            score_reg <= score_next;
            tag_reg   <= tag_next;
        end
    end

    assign score = score_reg;
    assign tag   = tag_reg;

endmodule

FILE: sv/top_k_product_score_tracker.sv
// Keeps the TOP_COUNT highest-scoring records in a sorted row of cells, slot 0
// on top. A record item (tuser = 0) is scored as the product of its seven Q0.16
// metrics, truncated to Q0.32 after each multiply, by one shared 32x16
// multiplier that takes one metric at a time, and is then inserted. It lands
// below equal scores and the bottom entry drops out; a zero score is never
// kept. A dump item (tuser = 1) gives TOP_COUNT items, highest first, empty
// slots as zero, tlast on the final one; the row rotates one slot per item
// taken and is back in place at the end. One item is worked on at a time:
// tready is low while a record is scored or a dump runs.
module top_k_product_score_tracker
    import tkpst_pkg::*;
#(
    parameter int TOP_COUNT = TOP_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // compare, pop, edges, clusters, slope, xmean, ymean metrics, coefficient_tag
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rank, score, coefficient_tag_res
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TOP_COUNT - 1);
    localparam int PAD_W = OUT_DATA_W - RANK_W - SCORE_W - TAG_W;

    state_t             state_reg, state_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [TAG_W-1:0]   tag_reg;
    metric_vec_t        in_metrics;
    logic               in_acc;
    logic               out_acc;
    logic               mul_start;
    logic               mul_done;
    logic [SCORE_W-1:0] mul_score;
    cell_ctrl_t         ctrl;

    logic [SCORE_W-1:0] cell_score [TOP_COUNT];
    logic [TAG_W-1:0]   cell_tag   [TOP_COUNT];
    logic               cell_gt    [TOP_COUNT];

    always_comb
    begin
        for (int j = 0; j < N_METRICS; j++)
        begin
            in_metrics[j] = s_tdata[j*METRIC_W +: METRIC_W];
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_DUMP);
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign mul_start = in_acc && (s_tuser == KIND_RECORD);
    assign ctrl      = '{ins: mul_done, rot: out_acc};

    always_comb
    begin
        state_next = state_reg;
        rank_next  = rank_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rank_next = '0;
                if (in_acc)
                begin
                    state_next = (s_tuser == KIND_DUMP) ? ST_DUMP : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_acc)
                begin
                    if (rank_reg == LAST_RANK)
                    begin
                        rank_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rank_next = rank_reg + RANK_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rank_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            tag_reg <= s_tdata[TAG_LSB +: TAG_W];
        end
    end

    tkpst_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .metrics (in_metrics),
        .done    (mul_done),
        .score   (mul_score)
    );

    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        logic               up_gt;
        logic [SCORE_W-1:0] up_score;
        logic [TAG_W-1:0]   up_tag;

        if (i == 0)
        begin : g_top
            assign up_gt    = 1'b0;
            assign up_score = '0;
            assign up_tag   = '0;
        end
        else
        begin : g_rest
            assign up_gt    = cell_gt[i-1];
            assign up_score = cell_score[i-1];
            assign up_tag   = cell_tag[i-1];
        end

        tkpst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .new_score (mul_score),
            .new_tag   (tag_reg),
            .up_gt     (up_gt),
            .up_score  (up_score),
            .up_tag    (up_tag),
            .dn_score  (cell_score[(i + 1) % TOP_COUNT]),
            .dn_tag    (cell_tag[(i + 1) % TOP_COUNT]),
            .gt        (cell_gt[i]),
            .score     (cell_score[i]),
            .tag       (cell_tag[i])
        );
    end

    assign m_tdata = {{PAD_W{1'b0}}, cell_tag[0], cell_score[0], rank_reg};
    assign m_tlast = (rank_reg == LAST_RANK);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("score finished outside scoring");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (rank_reg == '0)))
        else $error("dump did not return to idle");
`endif

endmodule
